>>> src/fba_pkg.sv
// Shared constants, codes and helpers for the frame bitmap allocator.
`timescale 1ns / 1ps
`default_nettype none
package fba_pkg;

    // Geometry
    localparam int MAX_FRAMES = 4096;
    localparam int WORD_BITS  = 32;
    localparam int NUM_WORDS  = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int FRAME_W    = 12;
    localparam int COUNT_W    = 13;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int WADDR_W    = $clog2(NUM_WORDS);
    localparam int WCNT_W     = WADDR_W + 1;
    localparam int OP_W       = 2;
    localparam int STAT_W     = 2;

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(4096);
    localparam logic [COUNT_W-1:0] COUNT_MAX   = COUNT_W'(MAX_FRAMES);

    // Request codes
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_MARK  = 2'd2;
    localparam logic [OP_W-1:0] OP_TEST  = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_FREE = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE   = 2'd2;

    typedef logic [WORD_BITS-1:0] t_word;

    // Bitmap port request from the controller
    typedef struct packed {
        logic               rd_en;
        logic [WADDR_W-1:0] rd_addr;
        logic               wr_en;
        logic [WADDR_W-1:0] wr_addr;
        t_word              wr_data;
    } t_mem_req;

    // Position of the lowest clear bit; only meaningful when one exists
    function automatic logic [BIT_W-1:0] f_lowest_zero(input t_word word);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!word[i]) begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

endpackage
`default_nettype wire

>>> src/fba_if.sv
// Request and response channel interfaces of the frame bitmap allocator.
`timescale 1ns / 1ps
`default_nettype none
interface fba_in_if;
    import fba_pkg::*;
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    opcode;
    logic [FRAME_W-1:0] frame_index;

    modport source (output valid, opcode, frame_index, input ready);
    modport sink   (input valid, opcode, frame_index, output ready);
endinterface

interface fba_out_if;
    import fba_pkg::*;
    logic               valid;
    logic               ready;
    logic [FRAME_W-1:0] result_frame;
    logic               frame_used;
    logic [STAT_W-1:0]  status;

    modport source (output valid, result_frame, frame_used, status, input ready);
    modport sink   (input valid, result_frame, frame_used, status, output ready);
endinterface
`default_nettype wire

>>> src/fba_bitmap.sv
// Frame bitmap store: synchronous word memory with registered read and per-word valid bits.
`timescale 1ns / 1ps
`default_nettype none
module fba_bitmap (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire fba_pkg::t_mem_req   i_req,
    output fba_pkg::t_word           o_rd_data
);
    import fba_pkg::*;

    t_word                  mem [NUM_WORDS];
    logic [NUM_WORDS-1:0]   r_valid;
    t_word                  r_q;
    logic                   r_q_vld;

    // Word array, registered read
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_q     <= mem[i_req.rd_addr];
            r_q_vld <= r_valid[i_req.rd_addr];
        end
    end

    // Words never written since reset read as all free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_q_vld ? r_q : '0;

endmodule
`default_nettype wire

>>> src/fba_ctrl.sv
// Request sequencer: word scan, read-modify-write and the result register.
`timescale 1ns / 1ps
`default_nettype none
module fba_ctrl (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    fba_in_if.sink                       i_in,
    fba_out_if.source                    o_out,
    input  wire [fba_pkg::COUNT_W-1:0]   i_eff_count,
    input  wire [fba_pkg::WCNT_W-1:0]    i_words,
    output fba_pkg::t_mem_req            o_mem_req,
    input  wire fba_pkg::t_word          i_rd_data
);
    import fba_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_RMW  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]         r_state,      n_state;
    logic [OP_W-1:0]    r_op,         n_op;
    logic [FRAME_W-1:0] r_idx,        n_idx;
    logic [WCNT_W-1:0]  r_rd_addr,    n_rd_addr;
    logic [WADDR_W-1:0] r_chk_addr,   n_chk_addr;
    logic [FRAME_W-1:0] r_res_frame,  n_res_frame;
    logic               r_res_used,   n_res_used;
    logic [STAT_W-1:0]  r_res_status, n_res_status;
    logic               r_out_valid,  n_out_valid;
    logic [FRAME_W-1:0] r_out_frame,  n_out_frame;
    logic               r_out_used,   n_out_used;
    logic [STAT_W-1:0]  r_out_status, n_out_status;

    logic [BIT_W-1:0]   w_zero_bit;
    logic [BIT_W-1:0]   w_req_bit;
    t_word              w_req_mask;
    t_mem_req           w_req;

    assign w_zero_bit = f_lowest_zero(i_rd_data);
    assign w_req_bit  = r_idx[BIT_W-1:0];
    assign w_req_mask = t_word'(1) << w_req_bit;

    // Next-state and bitmap port logic
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_idx        = r_idx;
        n_rd_addr    = r_rd_addr;
        n_chk_addr   = r_chk_addr;
        n_res_frame  = r_res_frame;
        n_res_used   = r_res_used;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_frame  = r_out_frame;
        n_out_used   = r_out_used;
        n_out_status = r_out_status;
        w_req        = '0;

        // result taken downstream
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_op  = i_in.opcode;
                    n_idx = i_in.frame_index;
                    if (i_in.opcode == OP_ALLOC) begin
                        if (i_words == '0) begin
                            n_res_frame  = '0;
                            n_res_used   = 1'b0;
                            n_res_status = ST_NO_FREE;
                            n_state      = S_DONE;
                        end else begin
                            w_req.rd_en   = 1'b1;
                            w_req.rd_addr = '0;
                            n_rd_addr     = WCNT_W'(1);
                            n_chk_addr    = '0;
                            n_state       = S_SCAN;
                        end
                    end else if ({1'b0, i_in.frame_index} >= i_eff_count) begin
                        n_res_frame  = i_in.frame_index;
                        n_res_used   = 1'b0;
                        n_res_status = ST_RANGE;
                        n_state      = S_DONE;
                    end else begin
                        w_req.rd_en   = 1'b1;
                        w_req.rd_addr = i_in.frame_index[FRAME_W-1:BIT_W];
                        n_state       = S_RMW;
                    end
                end
            end
            // one word checked per cycle while the next read is in flight
            S_SCAN: begin
                if (i_rd_data != '1) begin
                    w_req.wr_en   = 1'b1;
                    w_req.wr_addr = r_chk_addr;
                    w_req.wr_data = i_rd_data | (t_word'(1) << w_zero_bit);
                    n_res_frame   = {r_chk_addr, w_zero_bit};
                    n_res_used    = 1'b0;
                    n_res_status  = ST_DONE;
                    n_state       = S_DONE;
                end else if (r_rd_addr == i_words) begin
                    n_res_frame  = '0;
                    n_res_used   = 1'b0;
                    n_res_status = ST_NO_FREE;
                    n_state      = S_DONE;
                end else begin
                    w_req.rd_en   = 1'b1;
                    w_req.rd_addr = r_rd_addr[WADDR_W-1:0];
                    n_chk_addr    = r_rd_addr[WADDR_W-1:0];
                    n_rd_addr     = r_rd_addr + WCNT_W'(1);
                end
            end
            // free, mark or test one bit
            S_RMW: begin
                w_req.wr_addr = r_idx[FRAME_W-1:BIT_W];
                if (r_op == OP_FREE) begin
                    w_req.wr_en   = 1'b1;
                    w_req.wr_data = i_rd_data & ~w_req_mask;
                end else if (r_op == OP_MARK) begin
                    w_req.wr_en   = 1'b1;
                    w_req.wr_data = i_rd_data | w_req_mask;
                end
                n_res_frame  = r_idx;
                n_res_used   = i_rd_data[w_req_bit];
                n_res_status = ST_DONE;
                n_state      = S_DONE;
            end
            // hand the result to the output register once it has room
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_frame  = r_res_frame;
                    n_out_used   = r_res_used;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_idx        <= n_idx;
        r_rd_addr    <= n_rd_addr;
        r_chk_addr   <= n_chk_addr;
        r_res_frame  <= n_res_frame;
        r_res_used   <= n_res_used;
        r_res_status <= n_res_status;
        r_out_frame  <= n_out_frame;
        r_out_used   <= n_out_used;
        r_out_status <= n_out_status;
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.result_frame = r_out_frame;
    assign o_out.frame_used   = r_out_used;
    assign o_out.status       = r_out_status;
    assign o_mem_req          = w_req;

endmodule
`default_nettype wire

>>> src/frame_bitmap_allocator_top.sv
// Top level of the first-fit frame bitmap allocator.
`timescale 1ns / 1ps
`default_nettype none
// First-fit physical frame allocator. One bit per frame (set = used) lives in a
// 128 x 32-bit bitmap memory, all frames free after reset. A request beat
// allocates the lowest free frame, frees, marks or tests one frame; each
// produces exactly one response beat. Requests are handled one at a time:
// free and mark read the word and write it back, test only reads it;
// allocate scans bitmap words from word 0 up until it finds a clear bit.
// The scan rate is set by the single bitmap read port, one word per cycle.
// The next request is accepted in the cycle after the response is loaded.
// A finished response waits in an output register, so a new request is
// accepted while it is still pending; a second finished response waits
// until the first is taken. frames_in_use is written through i_cfg_wr_en /
// i_cfg_wr_data; the user must write it only while the block is idle, and
// the block itself does not enforce this. Values above 4096 saturate, and
// allocate only ever grants frames in whole words below the count.
module frame_bitmap_allocator_top (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    fba_in_if.sink                      i_in,
    fba_out_if.source                   o_out,
    input  wire                         i_cfg_wr_en,
    input  wire [fba_pkg::COUNT_W-1:0]  i_cfg_wr_data
);
    import fba_pkg::*;

    logic [COUNT_W-1:0] r_frames;
    logic [COUNT_W-1:0] w_eff_count;
    logic [WCNT_W-1:0]  w_words;
    t_mem_req           w_mem_req;
    t_word              w_rd_data;

    // frames_in_use register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames <= COUNT_RESET;
        end else if (i_cfg_wr_en) begin
            r_frames <= i_cfg_wr_data;
        end
    end

    // Saturated count and number of whole words below it
    assign w_eff_count = (r_frames > COUNT_MAX) ? COUNT_MAX : r_frames;
    assign w_words     = WCNT_W'(w_eff_count >> BIT_W);

    fba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_out       (o_out),
        .i_eff_count (w_eff_count),
        .i_words     (w_words),
        .o_mem_req   (w_mem_req),
        .i_rd_data   (w_rd_data)
    );

    fba_bitmap u_bitmap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_mem_req),
        .o_rd_data (w_rd_data)
    );

endmodule
`default_nettype wire

>>> src/fba_checker.sv
// Port-level checks for the frame bitmap allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module fba_checker (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    input  wire                         i_in_ready,
    input  wire                         i_out_valid,
    input  wire                         i_out_ready,
    input  wire [fba_pkg::FRAME_W-1:0]  i_out_frame,
    input  wire                         i_out_used,
    input  wire [fba_pkg::STAT_W-1:0]   i_out_status
);
    import fba_pkg::*;

    // No response beat straight after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("response valid after reset");

    // One request at a time: busy right after a request beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request accepted while busy");

    // A pending response stays until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("response dropped before taken");

    // No free frame answers frame 0, not used
    a_no_free_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status == ST_NO_FREE |-> i_out_frame == '0 && !i_out_used)
        else $error("no-free response with stray fields");

    // Out-of-range answers never report a used frame
    a_range_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status == ST_RANGE |-> !i_out_used)
        else $error("out-of-range response reports used");

endmodule

bind frame_bitmap_allocator_top fba_checker u_fba_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_frame  (o_out.result_frame),
    .i_out_used   (o_out.frame_used),
    .i_out_status (o_out.status)
);
`default_nettype wire
